/* hdl/rbsm_pkg.sv */
package rbsm_pkg;

    localparam int PAGE_OFFSET_BITS = 13;
    localparam int PAGES            = 8;
    localparam int BANK_BITS        = 9;
    localparam int OFFSET_BITS      = BANK_BITS + PAGE_OFFSET_BITS;

    // request modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    // mapper kinds
    localparam logic [2:0] KIND_ROM      = 3'd0;
    localparam logic [2:0] KIND_SWAP32K  = 3'd1;
    localparam logic [2:0] KIND_PAGE8K   = 3'd2;
    localparam logic [2:0] KIND_PAGE8K_U = 3'd3;
    localparam logic [2:0] KIND_WIN8K    = 3'd4;
    localparam logic [2:0] KIND_WIN16K   = 3'd5;
    localparam logic [2:0] KIND_RAM      = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_MAPPER_KIND  = 2'd0;
    localparam logic [1:0] CFG_ROM_SEGMENTS = 2'd1;
    localparam logic [1:0] CFG_RAM_SEGMENTS = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] rom_segs;
        logic [3:0] ram_segs;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{kind: KIND_ROM, rom_segs: 4'd8, ram_segs: 4'd8};

    typedef struct packed {
        logic                 valid;
        logic [BANK_BITS-1:0] bank;
    } t_entry;

    // bank switch request to the table
    typedef struct packed {
        logic       en;
        logic [2:0] page;
        logic [1:0] sub;   // address bits 12..11
        logic [7:0] data;
    } t_table_wr;

    function automatic t_entry pattern_entry(t_cfg cfg, logic [2:0] page);
        t_entry     e;
        logic [3:0] n;
        logic [3:0] r;
        e = '0;
        n = 4'd0;
        r = {1'b0, page};
        case (cfg.kind)
            KIND_ROM: begin
                n = cfg.rom_segs;
                if (n < 4'd1) n = 4'd1;
                if (n > 4'd8) n = 4'd8;
                // page < 8, so seven conditional subtracts reduce it mod n
                for (int k = 0; k < 7; k++) begin
                    if (r >= n) r = r - n;
                end
                e.valid = 1'b1;
                e.bank  = {6'd0, r[2:0]};
            end
            KIND_SWAP32K: begin
                e.valid = 1'b1;
                e.bank  = {7'd0, 2'(page[1:0] + 2'd2)};
            end
            KIND_PAGE8K, KIND_PAGE8K_U: begin
                if (page >= 3'd2 && page <= 3'd5) begin
                    e.valid = 1'b1;
                    e.bank  = {7'd0, 2'(page - 3'd2)};
                end
            end
            KIND_WIN8K: begin
                e.valid = 1'b1;
            end
            KIND_WIN16K: begin
                e.valid = 1'b1;
                e.bank  = {8'd0, page[0]};
            end
            KIND_RAM: begin
                n = cfg.ram_segs;
                if (n > 4'd8) n = 4'd8;
                if ({1'b0, page} < n) begin
                    e.valid = 1'b1;
                    e.bank  = {6'd0, page};
                end
            end
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

/* hdl/rbsm_bank_table.sv */
module rbsm_bank_table
    import rbsm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_reload,
    input  t_table_wr i_wr,
    input  logic [2:0] i_page,
    output t_entry    o_entry
);

    t_entry r_table [PAGES];
    t_entry n_table [PAGES];

    always_comb begin
        for (int p = 0; p < PAGES; p++) begin
            n_table[p] = r_table[p];
        end
        if (i_reload) begin
            for (int p = 0; p < PAGES; p++) begin
                n_table[p] = pattern_entry(i_cfg, 3'(p));
            end
        end else if (i_wr.en) begin
            case (i_cfg.kind)
                KIND_PAGE8K: begin
                    if (i_wr.page >= 3'd2 && i_wr.page <= 3'd5) begin
                        n_table[i_wr.page] = '{1'b1, {1'b0, i_wr.data}};
                    end
                end
                KIND_PAGE8K_U: begin
                    if (i_wr.page == 3'd4 || i_wr.page == 3'd5) begin
                        n_table[i_wr.page] = '{1'b1, {1'b0, i_wr.data}};
                    end
                end
                KIND_WIN8K: begin
                    if (i_wr.page == 3'd3) begin
                        n_table[3'(3'd2 + {1'b0, i_wr.sub})] = '{1'b1, {1'b0, i_wr.data}};
                    end
                end
                KIND_WIN16K: begin
                    // 16 KB window: even page gets 2*data, odd page 2*data+1
                    if (i_wr.page == 3'd3) begin
                        n_table[{1'b0, i_wr.sub[1], 1'b0} + 3'd2] = '{1'b1, {i_wr.data, 1'b0}};
                        n_table[{1'b0, i_wr.sub[1], 1'b0} + 3'd3] = '{1'b1, {i_wr.data, 1'b1}};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PAGES; p++) begin
                r_table[p] <= pattern_entry(CFG_RESET, 3'(p));
            end
        end else begin
            for (int p = 0; p < PAGES; p++) begin
                r_table[p] <= n_table[p];
            end
        end
    end

    assign o_entry = r_table[i_page];

endmodule

/* hdl/rom_bank_switch_mapper.sv */
// Cartridge bank mapper: translates CPU bus requests on a 64 KB space of
// eight 8 KB pages into memory offsets through an 8-entry bank table.
//
// s_axis: one bus request per transfer; tuser carries the mode (read, write,
// reset event), tdata the address and write byte. m_axis: one result per
// request with the memory offset, hit and RAM-write flags.
// cfg: register writes (mapper kind, ROM segments, RAM segments); each write
// reloads the power-on bank pattern with the new values. Write only while
// no request is in flight.
//
// Throughput is one request per cycle: a request is registered, then looked
// up in the bank table and its bank switch applied as the result register
// loads. When m_axis stalls, the result holds and one more request waits in
// the input register; tready drops only then.
// Synchronous reset restores mapper kind 0 with 8 ROM segments (page i maps
// to bank i) and empties both stages.
module rom_bank_switch_mapper
    import rbsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  i_s_axis_tuser,   // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // memory_offset[21:0], hit[22], write_memory[23]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    logic        r_in_valid;
    logic [1:0]  r_mode;
    logic [15:0] r_addr;
    logic [7:0]  r_data;

    logic                   r_out_valid;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_hit;
    logic                   r_wmem;

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic      advance;
    logic      cfg_we;
    logic      reload;
    t_table_wr table_wr;
    t_entry    entry;

    logic [OFFSET_BITS-1:0] n_offset;
    logic                   n_hit;
    logic                   n_wmem;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;

    assign cfg_we = i_cfg_valid && (i_cfg_index == CFG_MAPPER_KIND
                                 || i_cfg_index == CFG_ROM_SEGMENTS
                                 || i_cfg_index == CFG_RAM_SEGMENTS);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAPPER_KIND:  n_cfg.kind     = i_cfg_data[2:0];
                CFG_ROM_SEGMENTS: n_cfg.rom_segs = i_cfg_data;
                CFG_RAM_SEGMENTS: n_cfg.ram_segs = i_cfg_data;
                default: ;
            endcase
        end
    end

    assign reload = cfg_we || (advance && r_mode == MODE_RESET);

    assign table_wr.en   = advance && r_mode == MODE_WRITE;
    assign table_wr.page = r_addr[15:PAGE_OFFSET_BITS];
    assign table_wr.sub  = r_addr[12:11];
    assign table_wr.data = r_data;

    rbsm_bank_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (n_cfg),
        .i_reload (reload),
        .i_wr     (table_wr),
        .i_page   (r_addr[15:PAGE_OFFSET_BITS]),
        .o_entry  (entry)
    );

    always_comb begin
        n_offset = '0;
        n_hit    = 1'b0;
        n_wmem   = 1'b0;
        if (entry.valid) begin
            if (r_mode == MODE_READ) begin
                n_offset = {entry.bank, r_addr[PAGE_OFFSET_BITS-1:0]};
                n_hit    = 1'b1;
            end else if (r_mode == MODE_WRITE && r_cfg.kind == KIND_RAM) begin
                n_offset = {entry.bank, r_addr[PAGE_OFFSET_BITS-1:0]};
                n_hit    = 1'b1;
                n_wmem   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_mode <= i_s_axis_tuser;
            r_addr <= i_s_axis_tdata[15:0];
            r_data <= i_s_axis_tdata[23:16];
        end
        if (advance) begin
            r_offset <= n_offset;
            r_hit    <= n_hit;
            r_wmem   <= n_wmem;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_wmem, r_hit, r_offset};

endmodule

/* tb/sv/tb_rom_bank_switch_mapper.sv */
`timescale 1ns / 1ps

module tb_rom_bank_switch_mapper;
    import rbsm_pkg::*;

    // codes outside the package: the unused request mode and a register index with no register
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] CFG_NONE    = 2'd3;

    typedef struct packed {
        logic        wmem;
        logic        hit;
        logic [21:0] offset;
    } t_mapped_access;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        o_m_axis_tvalid;
    logic        m_tready;
    logic [23:0] o_m_axis_tdata;
    logic        cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    // shadow of the mapper: configuration and bank table
    logic [2:0]     cfg_kind;
    logic [3:0]     cfg_rom_segs;
    logic [3:0]     cfg_ram_segs;
    logic [8:0]     page_bank [8];
    bit             page_mapped [8];

    t_mapped_access pending_results [$];
    int             mismatch_count;
    bit             calm;

    rom_bank_switch_mapper dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    function automatic void set_bank(int page, int bank);
        page_bank[page & 7]   = 9'(bank);
        page_mapped[page & 7] = 1'b1;
    endfunction

    function automatic void reload_bank_pattern();
        int n;
        for (int p = 0; p < 8; p++) begin
            page_bank[p]   = '0;
            page_mapped[p] = 1'b0;
        end
        case (cfg_kind)
            KIND_ROM: begin
                n = (cfg_rom_segs == 0) ? 1 : ((cfg_rom_segs > 8) ? 8 : int'(cfg_rom_segs));
                for (int p = 0; p < 8; p++) set_bank(p, p % n);
            end
            KIND_SWAP32K: begin
                for (int p = 0; p < 8; p++) set_bank(p, (p + 2) % 4);
            end
            KIND_PAGE8K, KIND_PAGE8K_U: begin
                for (int i = 0; i < 4; i++) set_bank(2 + i, i);
            end
            KIND_WIN8K: begin
                for (int p = 0; p < 8; p++) set_bank(p, 0);
            end
            KIND_WIN16K: begin
                for (int p = 0; p < 8; p++) set_bank(p, p % 2);
            end
            KIND_RAM: begin
                n = (cfg_ram_segs > 8) ? 8 : int'(cfg_ram_segs);
                for (int p = 0; p < n; p++) set_bank(p, p);
            end
            default: ;
        endcase
    endfunction

    function automatic void apply_register(logic [1:0] index, logic [3:0] value);
        case (index)
            CFG_MAPPER_KIND:  cfg_kind = value[2:0];
            CFG_ROM_SEGMENTS: cfg_rom_segs = value;
            CFG_RAM_SEGMENTS: cfg_ram_segs = value;
            default: return;
        endcase
        reload_bank_pattern();
    endfunction

    function automatic t_mapped_access translate_request(logic [1:0] mode, logic [15:0] addr,
                                                         logic [7:0] data);
        t_mapped_access res;
        logic [2:0]     page;
        logic [12:0]    low;
        res  = '0;
        page = addr[15:13];
        low  = addr[12:0];
        case (mode)
            MODE_READ: begin
                if (page_mapped[page]) begin
                    res.offset = {page_bank[page], low};
                    res.hit    = 1'b1;
                end
            end
            MODE_WRITE: begin
                case (cfg_kind)
                    KIND_PAGE8K:   if (page >= 2 && page <= 5) set_bank(page, data);
                    KIND_PAGE8K_U: if (page == 4 || page == 5) set_bank(page, data);
                    KIND_WIN8K:    if (page == 3) set_bank(2 + addr[12:11], data);
                    KIND_WIN16K: begin
                        // window select is address bit 12; the pair gets an even/odd bank
                        if (page == 3) begin
                            set_bank(2 + 2 * addr[12], 2 * data);
                            set_bank(3 + 2 * addr[12], 2 * data + 1);
                        end
                    end
                    KIND_RAM: begin
                        if (page_mapped[page]) begin
                            res.offset = {page_bank[page], low};
                            res.hit    = 1'b1;
                            res.wmem   = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_RESET: reload_bank_pattern();
            default: ;
        endcase
        return res;
    endfunction

    function automatic int draw_gap();
        if (calm) return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    endfunction

    // request side
    task automatic send_request(logic [1:0] mode, logic [15:0] addr, logic [7:0] data);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        s_tuser  <= mode;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        pending_results.push_back(translate_request(mode, addr, data));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [3:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        apply_register(index, value);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic change_kind(logic [3:0] value);
        wait_idle();
        write_register(CFG_MAPPER_KIND, value);
    endtask

    task automatic send_random_request();
        logic [1:0]  mode;
        logic [15:0] addr;
        logic [7:0]  data;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 50)      mode = MODE_READ;
        else if (r < 88) mode = MODE_WRITE;
        else if (r < 96) mode = MODE_RESET;
        else             mode = MODE_UNUSED;
        addr = 16'($urandom_range(0, 16'hFFFF));
        data = 8'($urandom_range(0, 255));
        // steer most writes at the switch register pages of the current kind
        if (mode == MODE_WRITE && $urandom_range(0, 9) < 6) begin
            case (cfg_kind)
                KIND_WIN8K, KIND_WIN16K: addr[15:13] = 3'd3;
                KIND_PAGE8K_U:           addr[15:13] = 3'($urandom_range(4, 5));
                KIND_RAM, KIND_ROM:      ;
                default:                 addr[15:13] = 3'($urandom_range(2, 5));
            endcase
        end
        r = $urandom_range(0, 7);
        if (r == 0)      addr[12:0] = '0;
        else if (r == 1) addr[12:0] = '1;
        send_request(mode, addr, data);
    endtask

    // results: random stalls, each beat checked against the oldest prediction
    initial begin
        t_mapped_access got;
        t_mapped_access want;
        int             stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap();
            if (stall != 0) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                m_tready <= 1'b1;
            end
            do @(posedge i_clk); while (!(o_m_axis_tvalid === 1'b1 && m_tready));
            got = o_m_axis_tdata;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h with no request pending", got);
            end else begin
                want = pending_results.pop_front();
                if (got.offset !== want.offset || got.hit !== want.hit
                        || got.wmem !== want.wmem) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: offset %h exp %h, hit %b exp %b, wmem %b exp %b",
                                 got.offset, want.offset, got.hit, want.hit,
                                 got.wmem, want.wmem);
                end
            end
        end
    end

    task automatic test_directed_cases();
        // power-on map, address extremes, unused mode, ignored write, reset event
        send_request(MODE_READ, 16'h0000, 8'h00);
        send_request(MODE_READ, 16'hFFFF, 8'hFF);
        send_request(MODE_UNUSED, 16'hFFFF, 8'hFF);
        send_request(MODE_WRITE, 16'h4000, 8'hFF);
        send_request(MODE_RESET, 16'h0000, 8'h00);
        // per-page switch, unmapped pages, write outside the switch pages
        change_kind({1'b0, KIND_PAGE8K});
        send_request(MODE_WRITE, 16'h4000, 8'hFF);
        send_request(MODE_READ, 16'h5FFF, 8'h00);
        send_request(MODE_WRITE, 16'hA000, 8'h00);
        send_request(MODE_READ, 16'hBFFF, 8'h00);
        send_request(MODE_READ, 16'h0000, 8'h00);
        send_request(MODE_WRITE, 16'hC000, 8'h33);
        // index with no register leaves the table alone
        wait_idle();
        write_register(CFG_NONE, 4'h5);
        send_request(MODE_READ, 16'h4123, 8'h00);
        // switch limited to pages 4-5
        change_kind({1'b0, KIND_PAGE8K_U});
        send_request(MODE_WRITE, 16'h4000, 8'h77);
        send_request(MODE_WRITE, 16'h8000, 8'h12);
        send_request(MODE_READ, 16'h4000, 8'h00);
        send_request(MODE_READ, 16'h8123, 8'h00);
        // four 8 KB windows from page 3
        change_kind({1'b0, KIND_WIN8K});
        send_request(MODE_WRITE, 16'h7800, 8'hAA);
        send_request(MODE_WRITE, 16'h6000, 8'h01);
        send_request(MODE_READ, 16'hA000, 8'h00);
        // two 16 KB windows, top bank number
        change_kind({1'b0, KIND_WIN16K});
        send_request(MODE_WRITE, 16'h7000, 8'hFF);
        send_request(MODE_WRITE, 16'h6FFF, 8'h80);
        send_request(MODE_READ, 16'h9FFF, 8'h00);
        send_request(MODE_READ, 16'hA000, 8'h00);
        // RAM write, reset event, then the kind with nothing mapped
        change_kind({1'b0, KIND_RAM});
        send_request(MODE_WRITE, 16'hFFFF, 8'h5A);
        send_request(MODE_RESET, 16'h1234, 8'h00);
        change_kind(4'hF);
        send_request(MODE_READ, 16'h1234, 8'h00);
    endtask

    task automatic test_segment_sweep();
        change_kind({1'b0, KIND_ROM});
        for (int v = 0; v < 16; v++) begin
            wait_idle();
            write_register(CFG_ROM_SEGMENTS, 4'(v));
            for (int p = 0; p < 8; p++)
                send_request(MODE_READ, {3'(p), 13'($urandom)}, 8'($urandom));
        end
        change_kind({1'b0, KIND_RAM});
        for (int v = 0; v < 16; v++) begin
            wait_idle();
            write_register(CFG_RAM_SEGMENTS, 4'(v));
            for (int p = 0; p < 8; p++)
                send_request(p % 2 ? MODE_WRITE : MODE_READ, {3'(p), 13'($urandom)},
                             8'($urandom));
        end
    endtask

    // phases of random traffic, each under a fresh configuration; every phase
    // boundary drains all pending results before the registers change
    task automatic test_random_traffic(int count);
        int sent;
        int phase;
        int burst;
        int r;
        sent  = 0;
        phase = 0;
        while (sent < count) begin
            wait_idle();
            calm = ($urandom_range(0, 4) == 0);
            r    = $urandom_range(0, 3);
            write_register(CFG_ROM_SEGMENTS, r == 0 ? 4'd1 : (r == 1 ? 4'd8 : 4'($urandom)));
            write_register(CFG_RAM_SEGMENTS, r == 0 ? 4'd0 : (r == 1 ? 4'd8 : 4'($urandom)));
            if ($urandom_range(0, 5) == 0) write_register(CFG_NONE, 4'($urandom));
            if (phase < 8)
                write_register(CFG_MAPPER_KIND, 4'(phase));
            else if ($urandom_range(0, 9) == 0)
                write_register(CFG_MAPPER_KIND, 4'($urandom));
            else
                write_register(CFG_MAPPER_KIND, 4'($urandom_range(0, 6)));
            burst = $urandom_range(30, 90);
            for (int i = 0; i < burst; i++) send_random_request();
            sent  += burst;
            phase++;
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_READ;
        m_tready  = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAPPER_KIND;
        cfg_data  = '0;
        calm      = 1'b0;
        mismatch_count = 0;
        cfg_kind     = KIND_ROM;
        cfg_rom_segs = 4'd8;
        cfg_ram_segs = 4'd8;
        reload_bank_pattern();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_segment_sweep();
        test_random_traffic(1100);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* rom_bank_switch_mapper.f */
hdl/rbsm_pkg.sv
hdl/rbsm_bank_table.sv
hdl/rom_bank_switch_mapper.sv
tb/sv/tb_rom_bank_switch_mapper.sv
